// ===== hdl/bpf_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types for the
// breadcrumb path follower. No dependencies.

package bpf_pkg;

    // Item opcodes
    localparam logic [2:0] OP_POSE   = 3'd0;
    localparam logic [2:0] OP_SIGHT  = 3'd1;
    localparam logic [2:0] OP_CHECK  = 3'd2;
    localparam logic [2:0] OP_PAUSE  = 3'd3;
    localparam logic [2:0] OP_RESUME = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_SEPARATION = 2'd0;
    localparam logic [1:0] CFG_REACHED    = 2'd1;
    localparam logic [1:0] CFG_NEAR       = 2'd2;

    // Radius reset values in millimetres
    localparam logic [15:0] SEPARATION_RST = 16'd350;
    localparam logic [15:0] REACHED_RST    = 16'd250;
    localparam logic [15:0] NEAR_RST       = 16'd500;

    localparam int DEFAULT_PATH_DEPTH = 64;

    // Which distance test is running
    typedef enum logic [1:0] {
        DIST_NEAR,   // sighting vs robot, near radius
        DIST_SEP,    // sighting vs newest waypoint, separation radius
        DIST_REACH   // robot vs oldest waypoint, reached radius
    } dist_sel_t;

    // Waypoint store read address
    typedef enum logic [1:0] {
        RD_NEWEST,
        RD_OLDEST,
        RD_SECOND
    } rd_sel_t;

    // Operand of the shared squarer
    typedef enum logic [1:0] {
        MUL_X,
        MUL_Y,
        MUL_R
    } mul_step_t;

    // Source of the goal fields
    typedef enum logic [1:0] {
        GOAL_ZERO,
        GOAL_POINT,
        GOAL_STORE
    } goal_sel_t;

    typedef struct packed {
        logic      accept;
        logic      pose_wr;
        logic      pause_set;
        logic      pause_clr;
        logic      rd_en;
        rd_sel_t   rd_sel;
        dist_sel_t dist_sel;
        logic      diff_en;
        logic      mul_en;
        mul_step_t mul_step;
        logic      fifo_clr;
        logic      push;
        logic      pop;
        logic      res_load;
        logic      res_stop;
        logic      res_start;
        goal_sel_t res_goal;
        logic      res_perm_valid;
        logic      res_perm_allow;
        logic      res_center;
        logic      res_drop;
    } bpf_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       paused;
        logic       count_zero;
        logic       count_one;
        logic       count_full;
        logic       dist_lt;
        logic       dist_gt;
    } bpf_sts_t;

endpackage

// ===== hdl/bpf_ctrl.sv =====
// Sequencing state machine of the breadcrumb path follower.
// Depends on bpf_pkg; drives bpf_datapath through bpf_cmd_t.

module bpf_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               out_ready,
    output logic               out_valid,
    input  bpf_pkg::bpf_sts_t  sts,
    output bpf_pkg::bpf_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_DIFF   = 3'd2;
    localparam logic [2:0] S_SQX    = 3'd3;
    localparam logic [2:0] S_SQY    = 3'd4;
    localparam logic [2:0] S_SQR    = 3'd5;
    localparam logic [2:0] S_CMP    = 3'd6;
    localparam logic [2:0] S_NEXT   = 3'd7;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    bpf_pkg::dist_sel_t  job_reg;
    bpf_pkg::dist_sel_t  job_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        job_next     = job_reg;
        cmd          = '0;
        cmd.dist_sel = job_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (sts.op == bpf_pkg::OP_SIGHT && !sts.paused)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = bpf_pkg::RD_NEWEST;
                    job_next   = bpf_pkg::DIST_NEAR;
                    state_next = S_DIFF;
                end
                else if (sts.op == bpf_pkg::OP_CHECK && !sts.count_zero)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = bpf_pkg::RD_OLDEST;
                    job_next   = bpf_pkg::DIST_REACH;
                    state_next = S_DIFF;
                end
                else
                begin
                    if (out_free)
                    begin
                        // Pose, pause, resume and ignored items
                        cmd.res_load  = 1'b1;
                        cmd.pose_wr   = (sts.op == bpf_pkg::OP_POSE);
                        cmd.pause_set = (sts.op == bpf_pkg::OP_PAUSE);
                        cmd.fifo_clr  = (sts.op == bpf_pkg::OP_PAUSE);
                        cmd.res_stop  = (sts.op == bpf_pkg::OP_PAUSE);
                        cmd.pause_clr = (sts.op == bpf_pkg::OP_RESUME);
                        state_next    = S_IDLE;
                    end
                end
            end
            S_DIFF:
            begin
                cmd.diff_en = 1'b1;
                state_next  = S_SQX;
            end
            S_SQX:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = bpf_pkg::MUL_X;
                state_next   = S_SQY;
            end
            S_SQY:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = bpf_pkg::MUL_Y;
                state_next   = S_SQR;
            end
            S_SQR:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = bpf_pkg::MUL_R;
                state_next   = S_CMP;
            end
            S_CMP:
            begin
                unique case (job_reg)
                    bpf_pkg::DIST_NEAR:
                    begin
                        priority if (sts.dist_lt)
                        begin
                            // Person close by: stop and allow rotation
                            if (out_free)
                            begin
                                cmd.res_load       = 1'b1;
                                cmd.res_stop       = 1'b1;
                                cmd.res_perm_valid = 1'b1;
                                cmd.res_perm_allow = 1'b1;
                                cmd.fifo_clr       = 1'b1;
                                state_next         = S_IDLE;
                            end
                        end
                        else if (sts.count_zero)
                        begin
                            // First waypoint: append and head for it
                            if (out_free)
                            begin
                                cmd.res_load       = 1'b1;
                                cmd.push           = 1'b1;
                                cmd.res_start      = 1'b1;
                                cmd.res_goal       = bpf_pkg::GOAL_POINT;
                                cmd.res_perm_valid = 1'b1;
                                state_next         = S_IDLE;
                            end
                        end
                        else
                        begin
                            // Test spacing against the newest waypoint
                            job_next   = bpf_pkg::DIST_SEP;
                            state_next = S_DIFF;
                        end
                    end
                    bpf_pkg::DIST_SEP:
                    begin
                        if (out_free)
                        begin
                            cmd.res_load       = 1'b1;
                            cmd.res_perm_valid = 1'b1;
                            cmd.push           = sts.dist_gt && !sts.count_full;
                            cmd.res_drop       = sts.dist_gt && sts.count_full;
                            state_next         = S_IDLE;
                        end
                    end
                    bpf_pkg::DIST_REACH:
                    begin
                        priority if (!sts.dist_lt)
                        begin
                            if (out_free)
                            begin
                                cmd.res_load       = 1'b1;
                                cmd.res_perm_valid = 1'b1;
                                state_next         = S_IDLE;
                            end
                        end
                        else if (sts.count_one)
                        begin
                            // Last waypoint reached: stop and center the head
                            if (out_free)
                            begin
                                cmd.res_load       = 1'b1;
                                cmd.res_perm_valid = 1'b1;
                                cmd.res_center     = 1'b1;
                                cmd.res_stop       = 1'b1;
                                cmd.fifo_clr       = 1'b1;
                                state_next         = S_IDLE;
                            end
                        end
                        else
                        begin
                            // Fetch the next waypoint before popping
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = bpf_pkg::RD_SECOND;
                            state_next = S_NEXT;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_NEXT:
            begin
                if (out_free)
                begin
                    cmd.res_load       = 1'b1;
                    cmd.res_perm_valid = 1'b1;
                    cmd.res_start      = 1'b1;
                    cmd.res_goal       = bpf_pkg::GOAL_STORE;
                    cmd.pop            = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold a result until the downstream side takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= bpf_pkg::DIST_NEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/bpf_datapath.sv =====
// Datapath of the breadcrumb path follower: radii, robot pose, waypoint
// store and pointers, shared squarer, distance compare and result register.
// Depends on bpf_pkg; steered by bpf_ctrl.

module bpf_datapath
#(
    parameter int PATH_DEPTH = bpf_pkg::DEFAULT_PATH_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         opcode,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  bpf_pkg::bpf_cmd_t  cmd,
    output bpf_pkg::bpf_sts_t  sts,
    output logic               nav_stop,
    output logic               nav_start,
    output logic signed [15:0] goal_x,
    output logic signed [15:0] goal_y,
    output logic               perm_valid,
    output logic               perm_allow,
    output logic               center_head,
    output logic [6:0]         path_count,
    output logic               dropped
);

    localparam int PW = $clog2(PATH_DEPTH);
    localparam int CW = $clog2(PATH_DEPTH + 1);
    localparam int SW = CW + 1;

    // Configuration and control state
    logic [15:0]        sep_rad_reg;
    logic [15:0]        reach_rad_reg;
    logic [15:0]        near_rad_reg;
    logic signed [15:0] robot_x_reg;
    logic signed [15:0] robot_y_reg;
    logic               paused_reg;
    logic [PW-1:0]      ptr_reg;
    logic [PW-1:0]      ptr_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;

    // Item and arithmetic payload
    logic [2:0]         op_reg;
    logic signed [15:0] px_reg;
    logic signed [15:0] py_reg;
    logic [15:0]        abs_x_reg;
    logic [15:0]        abs_y_reg;
    logic [31:0]        sqx_reg;
    logic [31:0]        sqy_reg;
    logic [31:0]        sqr_reg;
    logic [31:0]        mem_q;
    logic [31:0]        mem [PATH_DEPTH];

    // Result register
    logic               stop_reg;
    logic               start_reg;
    logic signed [15:0] goal_x_reg;
    logic signed [15:0] goal_y_reg;
    logic               perm_valid_reg;
    logic               perm_allow_reg;
    logic               center_reg;
    logic [6:0]         path_count_reg;
    logic               drop_reg;

    logic [CW-1:0]      newest_off;
    logic [PW-1:0]      slot_tail;
    logic [PW-1:0]      slot_newest;
    logic [PW-1:0]      slot_second;
    logic [PW-1:0]      rd_idx;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [16:0]        ux;
    logic [16:0]        uy;
    logic [15:0]        rad;
    logic [15:0]        mul_op;
    logic [31:0]        prod;
    logic [32:0]        dist_sum;

    // Ring position oldest + off, with off at most the depth
    function automatic logic [PW-1:0] wrap_slot(input logic [PW-1:0] base,
                                                 input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(PATH_DEPTH))
        begin
            sum = sum - SW'(PATH_DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    // Ring addresses
    assign newest_off  = (count_reg == '0) ? '0 : count_reg - CW'(1);
    assign slot_tail   = wrap_slot(ptr_reg, count_reg);
    assign slot_newest = wrap_slot(ptr_reg, newest_off);
    assign slot_second = wrap_slot(ptr_reg, CW'(1));

    always_comb
    begin
        unique case (cmd.rd_sel)
            bpf_pkg::RD_NEWEST: rd_idx = slot_newest;
            bpf_pkg::RD_OLDEST: rd_idx = ptr_reg;
            bpf_pkg::RD_SECOND: rd_idx = slot_second;
            default:            rd_idx = ptr_reg;
        endcase
    end

    // Waypoint store: one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[slot_tail] <= {px_reg, py_reg};
        end
        if (cmd.rd_en)
        begin
            mem_q <= mem[rd_idx];
        end
    end

    // Distance operands and radius per test
    always_comb
    begin
        unique case (cmd.dist_sel)
            bpf_pkg::DIST_NEAR:
            begin
                a_x = px_reg;
                a_y = py_reg;
                b_x = robot_x_reg;
                b_y = robot_y_reg;
                rad = near_rad_reg;
            end
            bpf_pkg::DIST_SEP:
            begin
                a_x = px_reg;
                a_y = py_reg;
                b_x = mem_q[31:16];
                b_y = mem_q[15:0];
                rad = sep_rad_reg;
            end
            bpf_pkg::DIST_REACH:
            begin
                a_x = robot_x_reg;
                a_y = robot_y_reg;
                b_x = mem_q[31:16];
                b_y = mem_q[15:0];
                rad = reach_rad_reg;
            end
            default:
            begin
                a_x = px_reg;
                a_y = py_reg;
                b_x = robot_x_reg;
                b_y = robot_y_reg;
                rad = near_rad_reg;
            end
        endcase
    end

    // Absolute differences fit 16 bits unsigned
    assign dx = {a_x[15], a_x} - {b_x[15], b_x};
    assign dy = {a_y[15], a_y} - {b_y[15], b_y};
    assign ux = dx[16] ? 17'(-dx) : 17'(dx);
    assign uy = dy[16] ? 17'(-dy) : 17'(dy);

    // Shared squarer
    always_comb
    begin
        unique case (cmd.mul_step)
            bpf_pkg::MUL_X: mul_op = abs_x_reg;
            bpf_pkg::MUL_Y: mul_op = abs_y_reg;
            bpf_pkg::MUL_R: mul_op = rad;
            default:        mul_op = abs_x_reg;
        endcase
    end

    assign prod     = {16'd0, mul_op} * {16'd0, mul_op};
    assign dist_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // Status toward the controller
    assign sts.op         = op_reg;
    assign sts.paused     = paused_reg;
    assign sts.count_zero = (count_reg == '0);
    assign sts.count_one  = (count_reg == CW'(1));
    assign sts.count_full = (count_reg == CW'(PATH_DEPTH));
    assign sts.dist_lt    = (dist_sum < {1'b0, sqr_reg});
    assign sts.dist_gt    = (dist_sum > {1'b0, sqr_reg});

    // Ring pointer and fill count updates
    always_comb
    begin
        ptr_next   = ptr_reg;
        count_next = count_reg;
        priority if (cmd.fifo_clr)
        begin
            ptr_next   = '0;
            count_next = '0;
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            ptr_next   = slot_second;
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_rad_reg   <= bpf_pkg::SEPARATION_RST;
            reach_rad_reg <= bpf_pkg::REACHED_RST;
            near_rad_reg  <= bpf_pkg::NEAR_RST;
            robot_x_reg   <= '0;
            robot_y_reg   <= '0;
            paused_reg    <= 1'b0;
            ptr_reg       <= '0;
            count_reg     <= '0;
        end
        else
        begin
            // Configuration writes; indexes past the list are dropped
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    bpf_pkg::CFG_SEPARATION: sep_rad_reg   <= cfg_data;
                    bpf_pkg::CFG_REACHED:    reach_rad_reg <= cfg_data;
                    bpf_pkg::CFG_NEAR:       near_rad_reg  <= cfg_data;
                    default:                 ;
                endcase
            end
            if (cmd.pose_wr)
            begin
                robot_x_reg <= px_reg;
                robot_y_reg <= py_reg;
            end
            if (cmd.pause_set)
            begin
                paused_reg <= 1'b1;
            end
            else if (cmd.pause_clr)
            begin
                paused_reg <= 1'b0;
            end
            ptr_reg   <= ptr_next;
            count_reg <= count_next;
        end
    end

    // Capture the item, run the arithmetic steps, load the result
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= opcode;
            px_reg <= pos_x;
            py_reg <= pos_y;
        end
        if (cmd.diff_en)
        begin
            abs_x_reg <= ux[15:0];
            abs_y_reg <= uy[15:0];
        end
        if (cmd.mul_en)
        begin
            unique case (cmd.mul_step)
                bpf_pkg::MUL_X: sqx_reg <= prod;
                bpf_pkg::MUL_Y: sqy_reg <= prod;
                bpf_pkg::MUL_R: sqr_reg <= prod;
                default:        sqr_reg <= prod;
            endcase
        end
        if (cmd.res_load)
        begin
            stop_reg       <= cmd.res_stop;
            start_reg      <= cmd.res_start;
            perm_valid_reg <= cmd.res_perm_valid;
            perm_allow_reg <= cmd.res_perm_allow;
            center_reg     <= cmd.res_center;
            drop_reg       <= cmd.res_drop;
            path_count_reg <= 7'(count_next);
            unique case (cmd.res_goal)
                bpf_pkg::GOAL_POINT:
                begin
                    goal_x_reg <= px_reg;
                    goal_y_reg <= py_reg;
                end
                bpf_pkg::GOAL_STORE:
                begin
                    goal_x_reg <= mem_q[31:16];
                    goal_y_reg <= mem_q[15:0];
                end
                default:
                begin
                    goal_x_reg <= '0;
                    goal_y_reg <= '0;
                end
            endcase
        end
    end

    assign nav_stop    = stop_reg;
    assign nav_start   = start_reg;
    assign goal_x      = goal_x_reg;
    assign goal_y      = goal_y_reg;
    assign perm_valid  = perm_valid_reg;
    assign perm_allow  = perm_allow_reg;
    assign center_head = center_reg;
    assign path_count  = path_count_reg;
    assign dropped     = drop_reg;

endmodule

// ===== hdl/breadcrumb_path_follower.sv =====
// Top level of the breadcrumb path follower: controller plus datapath.
// Depends on bpf_pkg, bpf_ctrl and bpf_datapath.
//
//   channel | handshake               | payload
//   --------+-------------------------+-----------------------------------------
//   in      | in_valid / in_ready     | opcode, pos_x, pos_y
//   out     | out_valid / out_ready   | nav_stop, nav_start, goal_x, goal_y,
//           |                         | perm_valid, perm_allow, center_head,
//           |                         | path_count, dropped
//   cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data (always ready)
//
// One item at a time. Pose, pause, resume and ignored opcodes are answered from
// decode; a sighting runs one distance test, or a second one against the newest
// waypoint; a path check runs one test and may then read the next waypoint.
// Each distance test walks one shared 16x16 squarer through x, y and the
// radius, then one compare. A finished result sits in the output register
// while the next item is taken; the block stalls only when a second result is
// ready before the first is taken. Reset clears the pose, pause flag, ring
// pointer and fill count; the waypoint store needs no clearing pass.

module breadcrumb_path_follower
#(
    parameter int PATH_DEPTH = bpf_pkg::DEFAULT_PATH_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         opcode,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               nav_stop,
    output logic               nav_start,
    output logic signed [15:0] goal_x,
    output logic signed [15:0] goal_y,
    output logic               perm_valid,
    output logic               perm_allow,
    output logic               center_head,
    output logic [6:0]         path_count,
    output logic               dropped,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    bpf_pkg::bpf_cmd_t cmd;
    bpf_pkg::bpf_sts_t sts;

    // Register writes never stall
    assign cfg_ready = 1'b1;

    bpf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    bpf_datapath #(
        .PATH_DEPTH (PATH_DEPTH)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .opcode      (opcode),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .sts         (sts),
        .nav_stop    (nav_stop),
        .nav_start   (nav_start),
        .goal_x      (goal_x),
        .goal_y      (goal_y),
        .perm_valid  (perm_valid),
        .perm_allow  (perm_allow),
        .center_head (center_head),
        .path_count  (path_count),
        .dropped     (dropped)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for breadcrumb_path_follower: directed corners, a FIFO
// overflow and ring wrap, output backpressure and randomized follow trails.
// Depends on bpf_pkg and the breadcrumb_path_follower RTL.

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  PATH_DEPTH   = bpf_pkg::DEFAULT_PATH_DEPTH;
    localparam int  CLK_PERIOD   = 10;
    localparam int  OPCODE_SPACE = 8;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  SETTLE_CYCLES = 24;

    // One navigation command as the block reports it
    typedef struct {
        logic               nav_stop;
        logic               nav_start;
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic               perm_valid;
        logic               perm_allow;
        logic               center_head;
        logic [6:0]         path_count;
        logic               dropped;
    } nav_cmd_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         opcode = bpf_pkg::OP_POSE;
    logic signed [15:0] pos_x = '0;
    logic signed [15:0] pos_y = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               nav_stop;
    logic               nav_start;
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic               perm_valid;
    logic               perm_allow;
    logic               center_head;
    logic [6:0]         path_count;
    logic               dropped;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = bpf_pkg::CFG_SEPARATION;
    logic [15:0]        cfg_data = '0;

    // Follower state mirrored by the testbench
    logic [15:0]        sep_r   = bpf_pkg::SEPARATION_RST;
    logic [15:0]        reach_r = bpf_pkg::REACHED_RST;
    logic [15:0]        near_r  = bpf_pkg::NEAR_RST;
    logic signed [15:0] rob_x = '0;
    logic signed [15:0] rob_y = '0;
    bit                 is_paused = 1'b0;
    logic signed [15:0] wp_x [PATH_DEPTH];
    logic signed [15:0] wp_y [PATH_DEPTH];
    int                 wp_oldest = 0;
    int                 wp_count = 0;

    nav_cmd_t nav_cmds_due [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_request = 0;
    int stall_left = 0;
    int cycle_count = 0;
    int fail_count = 0;
    int results_seen = 0;
    int drops_seen = 0;
    int pops_seen = 0;
    int op_count [OPCODE_SPACE];

    breadcrumb_path_follower u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .nav_stop    (nav_stop),
        .nav_start   (nav_start),
        .goal_x      (goal_x),
        .goal_y      (goal_y),
        .perm_valid  (perm_valid),
        .perm_allow  (perm_allow),
        .center_head (center_head),
        .path_count  (path_count),
        .dropped     (dropped),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results still due",
                   cycle_count, nav_cmds_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Prediction
    //------------------------------------------------------------------

    function automatic longint sq_dist(input int ax, input int ay, input int bx, input int by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return dx * dx + dy * dy;
    endfunction

    function automatic longint sq_radius(input logic [15:0] r);
        longint rr;
        rr = longint'(r);
        return rr * rr;
    endfunction

    function automatic int ring_slot(input int offset);
        return (wp_oldest + offset) % PATH_DEPTH;
    endfunction

    // Apply one transaction to the mirrored state and return the command it yields
    function automatic nav_cmd_t predict_nav_cmd(input logic [2:0] op,
                                                 input logic signed [15:0] x,
                                                 input logic signed [15:0] y);
        nav_cmd_t c;
        int       newest;
        int       head;
        int       nxt;
        c = '{default: '0};
        case (op)
            bpf_pkg::OP_POSE:
            begin
                rob_x = x;
                rob_y = y;
            end
            bpf_pkg::OP_SIGHT:
            begin
                if (!is_paused)
                begin
                    c.perm_valid = 1'b1;
                    if (sq_dist(int'(x), int'(y), int'(rob_x), int'(rob_y)) <
                        sq_radius(near_r))
                    begin
                        // person came back to the robot: stop and forget the trail
                        c.nav_stop = 1'b1;
                        c.perm_allow = 1'b1;
                        wp_oldest = 0;
                        wp_count = 0;
                    end
                    else if (wp_count == 0)
                    begin
                        c.nav_start = 1'b1;
                        c.goal_x = x;
                        c.goal_y = y;
                        wp_x[ring_slot(0)] = x;
                        wp_y[ring_slot(0)] = y;
                        wp_count = 1;
                    end
                    else
                    begin
                        newest = ring_slot(wp_count - 1);
                        if (sq_dist(int'(x), int'(y), int'(wp_x[newest]), int'(wp_y[newest])) >
                            sq_radius(sep_r))
                        begin
                            if (wp_count >= PATH_DEPTH)
                                c.dropped = 1'b1;
                            else
                            begin
                                wp_x[ring_slot(wp_count)] = x;
                                wp_y[ring_slot(wp_count)] = y;
                                wp_count++;
                            end
                        end
                    end
                end
            end
            bpf_pkg::OP_CHECK:
            begin
                if (wp_count != 0)
                begin
                    head = ring_slot(0);
                    c.perm_valid = 1'b1;
                    if (sq_dist(int'(rob_x), int'(rob_y), int'(wp_x[head]), int'(wp_y[head])) <
                        sq_radius(reach_r))
                    begin
                        if (wp_count == 1)
                        begin
                            c.center_head = 1'b1;
                            c.nav_stop = 1'b1;
                            wp_oldest = 0;
                            wp_count = 0;
                        end
                        else
                        begin
                            nxt = ring_slot(1);
                            c.nav_start = 1'b1;
                            c.goal_x = wp_x[nxt];
                            c.goal_y = wp_y[nxt];
                            wp_oldest = nxt;
                            wp_count--;
                        end
                    end
                end
            end
            bpf_pkg::OP_PAUSE:
            begin
                is_paused = 1'b1;
                c.nav_stop = 1'b1;
                wp_oldest = 0;
                wp_count = 0;
            end
            bpf_pkg::OP_RESUME:
                is_paused = 1'b0;
            default: ;
        endcase
        c.path_count = 7'(wp_count);
        return c;
    endfunction

    //------------------------------------------------------------------
    // Result checking
    //------------------------------------------------------------------

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Compare each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        nav_cmd_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (nav_cmds_due.size() == 0)
            begin
                $error("result transaction with no prediction outstanding");
                fail_count++;
            end
            else
            begin
                want = nav_cmds_due.pop_front();
                check_field("nav_stop",    64'(want.nav_stop),    64'(nav_stop));
                check_field("nav_start",   64'(want.nav_start),   64'(nav_start));
                check_field("goal_x",      64'(want.goal_x),      64'(goal_x));
                check_field("goal_y",      64'(want.goal_y),      64'(goal_y));
                check_field("perm_valid",  64'(want.perm_valid),  64'(perm_valid));
                check_field("perm_allow",  64'(want.perm_allow),  64'(perm_allow));
                check_field("center_head", 64'(want.center_head), 64'(center_head));
                check_field("path_count",  64'(want.path_count),  64'(path_count));
                check_field("dropped",     64'(want.dropped),     64'(dropped));
            end
        end
    end

    // Result side: random stalls, or a long hold when a test asks for one
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_request != 0)
            begin
                stall_left = stall_request;
                stall_request = 0;
            end
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    // Offer one item, hold it until accepted, then record its prediction
    task automatic send_item(input logic [2:0] op, input logic signed [15:0] x,
                             input logic signed [15:0] y);
        nav_cmd_t c;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        pos_x    <= x;
        pos_y    <= y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        c = predict_nav_cmd(op, x, y);
        if (op == bpf_pkg::OP_CHECK && c.nav_start)
            pops_seen++;
        if (c.dropped)
            drops_seen++;
        nav_cmds_due.insert(nav_cmds_due.size(), c);
        op_count[op]++;
    endtask

    // Stop offering and wait for every predicted result
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (nav_cmds_due.size() != 0);
    endtask

    task automatic write_radius(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            bpf_pkg::CFG_SEPARATION: sep_r   = val;
            bpf_pkg::CFG_REACHED:    reach_r = val;
            bpf_pkg::CFG_NEAR:       near_r  = val;
            default: ;
        endcase
    endtask

    // Reprogram all three radii with the block idle
    task automatic set_radii(input logic [15:0] sep, input logic [15:0] reach,
                             input logic [15:0] near);
        drain_results();
        write_radius(bpf_pkg::CFG_SEPARATION, sep);
        write_radius(bpf_pkg::CFG_REACHED, reach);
        write_radius(bpf_pkg::CFG_NEAR, near);
        cfg_valid <= 1'b0;
    endtask

    function automatic int jitter(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Drive the robot onto the oldest waypoint and confirm arrival
    task automatic pop_waypoints(input int n);
        int k;
        for (k = 0; k < n; k++)
        begin
            send_item(bpf_pkg::OP_POSE, 16'(wp_x[ring_slot(0)] + jitter(100)),
                      16'(wp_y[ring_slot(0)] + jitter(100)));
            send_item(bpf_pkg::OP_CHECK, 16'($urandom), 16'($urandom));
        end
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Corners at reset radii: field extremes, exact radius boundaries, pause
    task automatic test_directed_cases();
        int op;
        send_item(bpf_pkg::OP_CHECK, '0, '0);
        send_item(bpf_pkg::OP_SIGHT, 16'(32767), 16'(32767));
        send_item(bpf_pkg::OP_SIGHT, 16'(-32768), 16'(-32768));
        send_item(bpf_pkg::OP_SIGHT, 16'(-32768), 16'(-32700));
        send_item(bpf_pkg::OP_CHECK, '0, '0);
        // exactly on the reached radius, then just inside it
        send_item(bpf_pkg::OP_POSE, 16'(32767), 16'(32517));
        send_item(bpf_pkg::OP_CHECK, '0, '0);
        send_item(bpf_pkg::OP_POSE, 16'(32767), 16'(32518));
        send_item(bpf_pkg::OP_CHECK, '0, '0);
        // last waypoint reached: center the head
        send_item(bpf_pkg::OP_POSE, 16'(-32768), 16'(-32768));
        send_item(bpf_pkg::OP_CHECK, '0, '0);
        // just inside, then exactly on the near radius
        send_item(bpf_pkg::OP_SIGHT, 16'(-32269), 16'(-32768));
        send_item(bpf_pkg::OP_SIGHT, 16'(-32268), 16'(-32768));
        // exactly on, then just past the separation radius
        send_item(bpf_pkg::OP_SIGHT, 16'(-31918), 16'(-32768));
        send_item(bpf_pkg::OP_SIGHT, 16'(-31917), 16'(-32768));
        // unused opcodes only report the count
        for (op = int'(bpf_pkg::OP_RESUME) + 1; op < OPCODE_SPACE; op++)
            send_item(3'(op), 16'($urandom), 16'($urandom));
        send_item(bpf_pkg::OP_PAUSE, 16'(-1), 16'(-1));
        send_item(bpf_pkg::OP_SIGHT, 16'(20000), 16'(20000));
        send_item(bpf_pkg::OP_POSE, 16'(123), 16'(-456));
        send_item(bpf_pkg::OP_CHECK, '0, '0);
        send_item(bpf_pkg::OP_RESUME, '0, '0);
        send_item(bpf_pkg::OP_SIGHT, 16'(623), 16'(-456));
        send_item(bpf_pkg::OP_SIGHT, 16'(123), 16'(-446));
        drain_results();
    endtask

    // Overfill the FIFO, pop part of it, refill across the ring wrap
    task automatic test_path_overflow();
        int i;
        send_item(bpf_pkg::OP_PAUSE, '0, '0);
        send_item(bpf_pkg::OP_RESUME, '0, '0);
        send_item(bpf_pkg::OP_POSE, '0, '0);
        for (i = 0; i < PATH_DEPTH + 4; i++)
            send_item(bpf_pkg::OP_SIGHT, 16'(-30000 + i * 450), 16'(20000));
        pop_waypoints(20);
        for (i = PATH_DEPTH + 4; i < PATH_DEPTH + 26; i++)
            send_item(bpf_pkg::OP_SIGHT, 16'(-30000 + i * 450), 16'(20000));
        pop_waypoints(10);
        send_item(bpf_pkg::OP_PAUSE, '0, '0);
        send_item(bpf_pkg::OP_RESUME, '0, '0);
        drain_results();
    endtask

    // Hold off the result side while items keep coming so the input stalls
    task automatic test_output_backpressure();
        int i;
        logic [2:0] op;
        drain_results();
        stall_request = 300;
        for (i = 0; i < 12; i++)
        begin
            op = 3'($urandom_range(int'(bpf_pkg::OP_RESUME)));
            send_item(op, 16'($urandom), 16'($urandom));
        end
        drain_results();
    endtask

    // Person walks, robot follows and checks its path, with noise mixed in
    task automatic run_trails(input int n_items);
        int n;
        int r;
        int step;
        int walk_x;
        int walk_y;
        walk_x = jitter(30000);
        walk_y = jitter(30000);
        step = $urandom_range(1500);
        for (n = 0; n < n_items; n++)
        begin
            r = $urandom_range(99);
            if (r < 2)
            begin
                // new episode somewhere else on the map
                walk_x = jitter(30000);
                walk_y = jitter(30000);
                step = $urandom_range(1500);
            end
            if (is_paused && r < 50)
                send_item(bpf_pkg::OP_RESUME, 16'($urandom), 16'($urandom));
            else if (r < 40)
            begin
                walk_x += jitter(step);
                walk_y += jitter(step);
                send_item(bpf_pkg::OP_SIGHT, 16'(walk_x), 16'(walk_y));
            end
            else if (r < 55)
            begin
                if (wp_count != 0)
                    send_item(bpf_pkg::OP_POSE,
                              16'(wp_x[ring_slot(0)] + jitter(int'($urandom_range(400)))),
                              16'(wp_y[ring_slot(0)] + jitter(int'($urandom_range(400)))));
                else
                    send_item(bpf_pkg::OP_POSE, 16'(walk_x + jitter(3000)),
                              16'(walk_y + jitter(3000)));
            end
            else if (r < 72)
                send_item(bpf_pkg::OP_CHECK, 16'($urandom), 16'($urandom));
            else if (r < 78)
                send_item(bpf_pkg::OP_SIGHT, 16'(rob_x + jitter(700)),
                          16'(rob_y + jitter(700)));
            else if (r < 81)
                send_item(bpf_pkg::OP_PAUSE, 16'($urandom), 16'($urandom));
            else if (r < 84)
                send_item(bpf_pkg::OP_RESUME, 16'($urandom), 16'($urandom));
            else if (r < 92)
                send_item(3'($urandom_range(OPCODE_SPACE - 1)), 16'($urandom), 16'($urandom));
            else
                send_item(bpf_pkg::OP_POSE, 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_random_trails();
        // extreme radii: every distinct point kept, everything reached, nobody near
        set_radii(16'd0, 16'hFFFF, 16'd0);
        run_trails(140);
        // swap the idling sides; opposite extremes
        set_radii(16'hFFFF, 16'd0, 16'hFFFF);
        send_idle_pct = 77;
        recv_idle_pct = 35;
        run_trails(100);
        // no idling, realistic radii
        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_radii(16'($urandom_range(100, 800)), 16'($urandom_range(100, 600)),
                  16'($urandom_range(200, 1500)));
        run_trails(110);
        set_radii(16'($urandom_range(100, 800)), 16'($urandom_range(100, 600)),
                  16'($urandom_range(200, 1500)));
        run_trails(110);
        drain_results();
    endtask

    //------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------

    initial
    begin
        int unused_ops;
        int k;
        foreach (op_count[i])
            op_count[i] = 0;
        send_idle_pct = 35;
        recv_idle_pct = 77;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_path_overflow();
        test_output_backpressure();
        test_random_trails();

        repeat (SETTLE_CYCLES) @(posedge clk);
        unused_ops = 0;
        for (k = int'(bpf_pkg::OP_RESUME) + 1; k < OPCODE_SPACE; k++)
            unused_ops += op_count[k];
        $display("Covered %0d results: pose %0d, sighting %0d, check %0d, pause %0d, resume %0d,",
                 results_seen, op_count[bpf_pkg::OP_POSE], op_count[bpf_pkg::OP_SIGHT],
                 op_count[bpf_pkg::OP_CHECK], op_count[bpf_pkg::OP_PAUSE],
                 op_count[bpf_pkg::OP_RESUME]);
        $display("  unused opcodes %0d, waypoint pops %0d, full-FIFO drops %0d, %0d mismatches",
                 unused_ops, pops_seen, drops_seen, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bpf_pkg.sv
hdl/bpf_ctrl.sv
hdl/bpf_datapath.sv
hdl/breadcrumb_path_follower.sv
dv/tb_top.sv
